// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker. They expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srts_pkg.sv -----
// ---------------------------------------------------------------------------
// srts_pkg
// Shared widths, codes and types of the radix-to-text converter.
// ---------------------------------------------------------------------------
`default_nettype none

package srts_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int MAX_SYMBOLS    = 16;
    localparam int IN_W           = 32;
    localparam int SYM_W          = 8;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int BASE_LEN_W     = 5;
    localparam int SYMS_PER_WORD  = CFG_W / SYM_W;
    localparam int DIGIT_W        = $clog2(MAX_SYMBOLS);
    localparam int RADIX_W        = DIGIT_W + 1;
    localparam int COUNT_W        = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W          = $clog2(VALUE_WIDTH);
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W          = DIV_CYCLES * BITS_PER_CYCLE;
    localparam int STEP_W         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_SYMBOLS_LOW  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SYMBOLS_HIGH = cfg_idx_t'(1);
    localparam cfg_idx_t REG_BASE_LENGTH  = cfg_idx_t'(2);

    typedef logic [SYM_W-1:0] symbol_t;
    typedef symbol_t [MAX_SYMBOLS-1:0] alphabet_t;

    localparam symbol_t MINUS_CHAR = 8'h2D;
    localparam symbol_t PLUS_CHAR  = 8'h2B;
    localparam symbol_t NUL_CHAR   = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic digit_end;
    } divctl_t;

    typedef struct packed {
        logic               quo_zero;
        logic [DIGIT_W-1:0] rem;
    } divres_t;

endpackage

`default_nettype wire

// ----- sv/srts_if.sv -----
// ---------------------------------------------------------------------------
// srts_if
// Valid/ready channels: numbers in, characters out.
// ---------------------------------------------------------------------------
`default_nettype none

interface srts_num_if import srts_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srts_text_if import srts_pkg::*;;
    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/signed_radix_to_symbols.sv -----
// A number is accepted, the alphabet is checked, then the shared divider works
// out the digits one after another; the characters, sign first, go one by one
// into the output register, held while the receiver stalls. An invalid alphabet
// gives no words.
// The divider retires 8 quotient bits a cycle; ready is high only when idle.
// Reset (rst_n low, async): control state cleared, no word pending, ready when idle.
// ---------------------------------------------------------------------------
// signed_radix_to_symbols
// Renders signed numbers as text in a configurable base and alphabet.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_radix_to_symbols import srts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire cfg_idx_t         cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    srts_num_if.sink              number,
    srts_text_if.source           text
);

    alphabet_t          alphabet;
    logic [RADIX_W-1:0] radix;
    logic               base_ok;
    divctl_t            ctl;
    divres_t            res;

    srts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .alphabet  (alphabet),
        .radix     (radix),
        .base_ok   (base_ok)
    );

    srts_div u_div (
        .clk   (clk),
        .value (number.value[VALUE_WIDTH-1:0]),
        .radix (radix),
        .ctl   (ctl),
        .res   (res)
    );

    srts_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .number   (number),
        .text     (text),
        .alphabet (alphabet),
        .base_ok  (base_ok),
        .res      (res),
        .ctl      (ctl)
    );

endmodule

`default_nettype wire

// ----- sv/srts_cfg.sv -----
// ---------------------------------------------------------------------------
// srts_cfg
// Configuration registers and alphabet validity check.
// ---------------------------------------------------------------------------
`default_nettype none

module srts_cfg import srts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire cfg_idx_t           cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output alphabet_t               alphabet,
    output logic [RADIX_W-1:0]      radix,
    output logic                    base_ok
);

    logic [CFG_W-1:0]      sym_low_reg;
    logic [CFG_W-1:0]      sym_high_reg;
    logic [BASE_LEN_W-1:0] base_len_reg;
    logic [2*CFG_W-1:0]    sym_flat;
    logic                  bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            base_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                REG_BASE_LENGTH:  base_len_reg <= cfg_data[BASE_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign sym_flat = {sym_high_reg, sym_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            alphabet[i] = sym_flat[i*SYM_W +: SYM_W];
        end
    end

    // symbols past the length are don't-care; j > i in use implies i in use
    always_comb
    begin
        bad = (base_len_reg < BASE_LEN_W'(2)) || (base_len_reg > BASE_LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (BASE_LEN_W'(i) < base_len_reg)
            begin
                if (alphabet[i] == NUL_CHAR || alphabet[i] == PLUS_CHAR ||
                    alphabet[i] == MINUS_CHAR)
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (BASE_LEN_W'(j) < base_len_reg && alphabet[i] == alphabet[j])
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign base_ok = !bad;
    assign radix   = base_len_reg[RADIX_W-1:0];

endmodule

`default_nettype wire

// ----- sv/srts_div.sv -----
// ---------------------------------------------------------------------------
// srts_div
// Shared restoring divider by the radix, several quotient bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module srts_div import srts_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic [RADIX_W-1:0]     radix,
    input  wire divctl_t                ctl,
    output divres_t                     res
);

    logic [PAD_W-1:0]       shift_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [PAD_W-1:0]       shift_next;
    logic [DIGIT_W-1:0]     rem_next;
    logic [VALUE_WIDTH-1:0] magnitude;

    // two's complement magnitude; the most negative value maps to 2^(w-1)
    assign magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        logic [RADIX_W-1:0] trial;
        logic [PAD_W-1:0]   sh;
        logic [DIGIT_W-1:0] rm;
        sh = shift_reg;
        rm = rem_reg;
        for (int k = 0; k < BITS_PER_CYCLE; k++)
        begin
            trial = {rm, sh[PAD_W-1]};
            sh    = {sh[PAD_W-2:0], 1'b0};
            if (trial >= radix)
            begin
                trial = trial - radix;
                sh[0] = 1'b1;
            end
            rm = trial[DIGIT_W-1:0];
        end
        shift_next = sh;
        rem_next   = rm;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            shift_reg <= PAD_W'(magnitude);
            rem_reg   <= '0;
        end
        else if (ctl.step)
        begin
            shift_reg <= shift_next;
            rem_reg   <= ctl.digit_end ? '0 : rem_next;
        end
    end

    assign res.rem      = rem_next;
    assign res.quo_zero = (shift_next == '0);

endmodule

`default_nettype wire

// ----- sv/srts_seq.sv -----
// ---------------------------------------------------------------------------
// srts_seq
// Sequencer: drives the divider, stacks digits, emits characters.
// ---------------------------------------------------------------------------
`default_nettype none

module srts_seq import srts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    srts_num_if.sink       number,
    srts_text_if.source    text,
    input  wire alphabet_t alphabet,
    input  wire logic      base_ok,
    input  wire divres_t   res,
    output divctl_t        ctl
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                sign_reg, sign_next;
    logic                out_valid_reg, out_valid_next;
    symbol_t             out_symbol_reg, out_symbol_next;
    logic                out_last_reg, out_last_next;
    logic [DIGIT_W-1:0]  stack_reg [VALUE_WIDTH];
    logic                stack_we;
    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  count_dec;
    logic                load_out;

    assign count_inc = count_reg + COUNT_W'(1);
    assign count_dec = count_reg - COUNT_W'(1);
    assign load_out  = !out_valid_reg || text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        if (stack_we)
        begin
            stack_reg[count_reg[IDX_W-1:0]] <= res.rem;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        sign_next       = sign_reg;
        out_valid_next  = out_valid_reg && !text.ready;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        stack_we        = 1'b0;
        ctl             = '0;
        number.ready    = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    ctl.load   = 1'b1;
                    sign_next  = number.value[VALUE_WIDTH-1];
                    count_next = '0;
                    step_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = base_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                ctl.step = 1'b1;
                if (step_reg == STEP_W'(DIV_CYCLES - 1))
                begin
                    // one digit done: push remainder, quotient is next dividend
                    ctl.digit_end = 1'b1;
                    stack_we      = 1'b1;
                    count_next    = count_inc;
                    step_next     = '0;
                    if (res.quo_zero || count_inc >= COUNT_W'(VALUE_WIDTH))
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        out_symbol_next = MINUS_CHAR;
                        out_last_next   = 1'b0;
                        sign_next       = 1'b0;
                    end
                    else
                    begin
                        out_symbol_next = alphabet[stack_reg[count_dec[IDX_W-1:0]]];
                        out_last_next   = (count_reg == COUNT_W'(1));
                        count_next      = count_dec;
                        if (count_reg == COUNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign text.valid  = out_valid_reg;
    assign text.symbol = out_symbol_reg;
    assign text.last   = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/srts_checker.sv -----
// ---------------------------------------------------------------------------
// srts_checker
// Port-level checks on the converter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srts_checker import srts_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    num_valid,
    input wire logic    num_ready,
    input wire logic    text_valid,
    input wire logic    text_ready,
    input wire symbol_t text_symbol,
    input wire logic    text_last
);

    `CHK_NEXT(a_text_hold, text_valid && !text_ready, text_valid && $stable(text_symbol) && $stable(text_last), "stalled word changed")

    `CHK_NEXT(a_busy_after_take, num_valid && num_ready, !num_ready, "ready after taking a number")

    `CHK_NOW(a_minus_not_last, text_valid && text_symbol == MINUS_CHAR, !text_last, "sign flagged as last")

    `CHK_NOW(a_no_nul, text_valid, text_symbol != NUL_CHAR, "zero symbol emitted")

endmodule

bind signed_radix_to_symbols srts_checker u_srts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .num_valid   (number.valid),
    .num_ready   (number.ready),
    .text_valid  (text.valid),
    .text_ready  (text.ready),
    .text_symbol (text.symbol),
    .text_last   (text.last)
);

`default_nettype wire

// ----- dv/tb_signed_radix_to_symbols.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_signed_radix_to_symbols
// Drives signed numbers through the radix-to-text converter under a range of
// alphabets and radixes, valid and broken, and checks every character word
// against a local rendering of the number or its typed text, with random stalls on both sides.
// ---------------------------------------------------------------------------

module tb_signed_radix_to_symbols;
    import srts_pkg::*;

    localparam cfg_idx_t REG_UNUSED    = cfg_idx_t'(3);
    localparam int       SETTLE_CYCLES = 10;
    localparam int       DRAIN_CYCLES  = 200;
    localparam int       STALL_LIMIT   = 2000;
    localparam int       HOLD_CYCLES   = 300;
    localparam int       RANDOM_ITEMS  = 95;

    typedef struct packed {
        symbol_t symbol;
        logic    last;
    } text_word_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_NUMBER,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        cfg_idx_t               index;
        logic [CFG_W-1:0]       data;
        logic signed [IN_W-1:0] value;
        string                  shown;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    cfg_idx_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    srts_num_if  num_ch ();
    srts_text_if text_ch ();

    signed_radix_to_symbols dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (num_ch),
        .text      (text_ch)
    );

    always #10 clk = ~clk;

    // local copy of the configuration registers
    logic [CFG_W-1:0]      alpha_lo;
    logic [CFG_W-1:0]      alpha_hi;
    logic [BASE_LEN_W-1:0] radix_len;

    text_word_t chars_due[$];
    int fail_count    = 0;
    int words_seen    = 0;
    int numbers_sent  = 0;
    int phase_count   = 0;
    int bad_phases    = 0;
    bit sender_quiet  = 1'b0;

    function automatic bit alphabet_valid();
        alphabet_t alpha;
        alpha = {alpha_hi, alpha_lo};
        if (radix_len < 2 || radix_len > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < radix_len; i++)
        begin
            if (alpha[i] == NUL_CHAR || alpha[i] == PLUS_CHAR || alpha[i] == MINUS_CHAR)
                return 1'b0;
            for (int j = i + 1; j < radix_len; j++)
                if (alpha[j] == alpha[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // pushes the characters of one number, sign first, most significant digit next
    function automatic void render_number(input logic [IN_W-1:0] v);
        alphabet_t            alpha;
        logic [VALUE_WIDTH:0] mag;
        logic [DIGIT_W-1:0]   digits[$];
        bit                   neg;
        alpha = {alpha_hi, alpha_lo};
        if (!alphabet_valid())
            return;
        neg = v[VALUE_WIDTH-1];
        // one bit wider, so the most negative value keeps its magnitude
        mag = neg ? ({1'b0, ~v[VALUE_WIDTH-1:0]} + 1'b1) : {1'b0, v[VALUE_WIDTH-1:0]};
        do
        begin
            digits.push_front(DIGIT_W'(mag % radix_len));
            mag = mag / radix_len;
        end
        while (mag != 0);
        if (neg)
            chars_due.push_back('{MINUS_CHAR, 1'b0});
        for (int i = 0; i < digits.size(); i++)
            chars_due.push_back('{alpha[digits[i]], i == digits.size() - 1});
    endfunction

    function automatic void queue_text(input string shown);
        for (int i = 0; i < shown.len(); i++)
            chars_due.push_back('{symbol_t'(shown[i]), i == shown.len() - 1});
    endfunction

    // waits for every expected word, then lets a trailing invalid number finish
    task automatic settle();
        num_ch.valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SYMBOLS_LOW:  alpha_lo  = data;
            REG_SYMBOLS_HIGH: alpha_hi  = data;
            REG_BASE_LENGTH:  radix_len = data[BASE_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_number(input logic signed [IN_W-1:0] v, input bit typed,
                               input string shown);
        int gap;
        gap = 0;
        if (!sender_quiet && $urandom_range(99) < 38)
            gap = $urandom_range(1, 40);
        if (gap > 0)
        begin
            num_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= v;
        do
            @(posedge clk);
        while (!num_ch.ready);
        numbers_sent++;
        if (typed)
            queue_text(shown);
        else
            render_number(v);
    endtask

    // output check
    always @(posedge clk)
    begin
        text_word_t want;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            words_seen++;
            if (chars_due.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got symbol 8'h%02h last %0b",
                         $time, text_ch.symbol, text_ch.last);
                fail_count++;
            end
            else
            begin
                want = chars_due.pop_front();
                if (text_ch.symbol !== want.symbol)
                begin
                    $display("%0t: symbol mismatch: expected 8'h%02h, got 8'h%02h",
                             $time, want.symbol, text_ch.symbol);
                    fail_count++;
                end
                if (text_ch.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, text_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        text_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && words_seen >= 250)
            begin
                held = 1'b1;
                text_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (words_seen >= 600 && words_seen < 800)
                text_ch.ready <= 1'b1;
            else
                text_ch.ready <= ($urandom_range(99) >= 38);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no handshake for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("signed_radix_to_symbols test failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t              stim_table[$];
        stim_row_t              row;
        alphabet_t              alpha;
        symbol_t                b;
        bit                     clash;
        bit                     bad;
        int                     radix;
        int                     k;
        int                     items;
        int                     counted;
        logic signed [IN_W-1:0] v;

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_SYMBOLS_LOW;
        cfg_data     = '0;
        num_ch.valid = 1'b0;
        num_ch.value = '0;
        alpha_lo     = '0;
        alpha_hi     = '0;
        radix_len    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length alphabet after reset
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd5, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130, '0, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_HIGH, 64'h6665_6463_6261_3938, '0, ""});
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd10, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd0, "0"});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sh7FFF_FFFF, "2147483647"});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sh8000_0000, "-2147483648"});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, -32'sd1, "-1"});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sd305419896, ""});
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd16, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sh8000_0000, "-80000000"});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sh7FFF_FFFF, "7fffffff"});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'shDEAD_BEEF, ""});
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd2, '0, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sh8000_0000, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sh7FFF_FFFF, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sd0, ""});
        // radix too small, then too large
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd1, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd100, ""});
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd17, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd100, ""});
        // only the low five bits of the length count
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3, '0, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sh8000_0000, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, 32'sd12345, ""});
        stim_table.push_back('{ROW_WRITE, REG_UNUSED, '1, '0, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, -32'sd12345, ""});
        // plus, minus, nul and a repeat inside a full alphabet
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd16, '0, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_LOW, 64'h3736_2B34_3332_3130, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd1, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_LOW, 64'h3736_3534_332D_3130, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd1, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_LOW, 64'h0036_3534_3332_3130, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd1, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130, '0, ""});
        stim_table.push_back('{ROW_WRITE, REG_SYMBOLS_HIGH, 64'h3065_6463_6261_3938, '0, ""});
        stim_table.push_back('{ROW_TYPED, REG_SYMBOLS_LOW, '0, 32'sd1, ""});
        // the repeat now sits beyond the radix and no longer matters
        stim_table.push_back('{ROW_WRITE, REG_BASE_LENGTH, 64'd10, '0, ""});
        stim_table.push_back('{ROW_NUMBER, REG_SYMBOLS_LOW, '0, -32'sd987654321, ""});

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == ROW_WRITE)
            begin
                settle();
                write_reg(row.index, row.data);
            end
            else
                send_number(row.value, row.kind == ROW_TYPED, row.shown);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            settle();
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                do
                begin
                    b = symbol_t'($urandom_range(1, 255));
                    clash = (b == PLUS_CHAR) || (b == MINUS_CHAR);
                    for (int j = 0; j < i; j++)
                        if (alpha[j] == b)
                            clash = 1'b1;
                end
                while (clash);
                alpha[i] = b;
            end
            if (phase_count == 0)
                radix = 2;
            else if (phase_count == 1)
                radix = MAX_SYMBOLS;
            else if ($urandom_range(99) < 10)
                radix = $urandom_range(1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
            else
                radix = $urandom_range(2, MAX_SYMBOLS);
            // symbols past the radix are unused and may be anything
            for (int i = radix; i < MAX_SYMBOLS; i++)
                alpha[i] = symbol_t'($urandom_range(0, 255));
            bad = (radix < 2) || (radix > MAX_SYMBOLS);
            if (!bad && phase_count > 1 && $urandom_range(5) == 0)
            begin
                bad = 1'b1;
                k = $urandom_range(0, radix - 1);
                case ($urandom_range(3))
                    0: alpha[k] = NUL_CHAR;
                    1: alpha[k] = PLUS_CHAR;
                    2: alpha[k] = MINUS_CHAR;
                    default: alpha[k] = alpha[(k + 1) % radix];
                endcase
            end
            write_reg(REG_SYMBOLS_LOW, alpha[SYMS_PER_WORD-1:0]);
            write_reg(REG_SYMBOLS_HIGH, alpha[MAX_SYMBOLS-1:SYMS_PER_WORD]);
            write_reg(REG_BASE_LENGTH,
                      {$urandom, $urandom} & ~64'h1F | CFG_W'(radix & 'h1F));
            phase_count++;
            if (bad)
                bad_phases++;
            items = bad ? 3 : $urandom_range(6, 14);
            for (int n = 0; n < items; n++)
            begin
                sender_quiet = (counted >= 40 && counted < 70);
                case ($urandom_range(9))
                    0: v = '0;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sh7FFF_FFFF;
                    3: v = 0 - $urandom_range(1, 16);
                    4, 5: v = $urandom_range(0, 2000) - 1000;
                    default: v = $urandom;
                endcase
                send_number(v, 1'b0, "");
                if (!bad)
                    counted++;
            end
        end

        num_ch.valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d numbers and %0d character words", numbers_sent, words_seen);
        $display("random part went through %0d alphabet settings, %0d of them rejected",
                 phase_count, bad_phases);
        if (fail_count == 0)
            $display("signed_radix_to_symbols test passed");
        else
            $display("signed_radix_to_symbols test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/srts_pkg.sv
sv/srts_if.sv
sv/srts_cfg.sv
sv/srts_div.sv
sv/srts_seq.sv
sv/signed_radix_to_symbols.sv
sv/srts_checker.sv
dv/tb_signed_radix_to_symbols.sv
